// ===== sv/psw_pkg.sv =====
// Shared types and constants of the per-slot window average core.
package psw_pkg;

    localparam int NUM_SLOTS_DEF  = 16;
    localparam int MAX_WINDOW_DEF = 16;

    localparam int SLOT_ID_W  = 4;
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 5;
    localparam int CFG_W      = 5;

    // func codes
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [SLOT_ID_W-1:0] slot_id;
        logic [SAMPLE_W-1:0]  queue_sample;
        logic [SAMPLE_W-1:0]  rate_sample;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean_queue;
        logic [SAMPLE_W-1:0] mean_rate;
        logic [COUNT_W-1:0]  samples_held;
    } t_out_word;

endpackage

// ===== sv/psw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module psw_ram #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/psw_div_serial.sv =====
// Restoring divider, one quotient bit per cycle.
module psw_div_serial #(
    parameter int DW = 20,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_quo, n_quo;
    logic [VW-1:0]    r_rem, n_rem;
    logic [VW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VW:0]      w_trial;
    logic [VW:0]      w_diff;
    logic             w_ge;

    // shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
        n_quo   = {r_quo[DW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== sv/per_slot_window_average_core.sv =====
// Top level of the per-slot sliding-window average core.
//
// Each slot keeps a ring of its most recent (queue, rate) sample pairs in two RAMs,
// plus running sums, an oldest position and a fill count in flops. A push word adds
// a pair (evicting the oldest once the window is full); a query word only reads.
// Every word returns sum / count for both samples, truncated, and the count; an
// empty window or a slot_id at or above NUM_SLOTS returns all zeros. The two means
// come from a pair of bit-serial restoring dividers running in lockstep, one
// quotient bit a cycle over SUM_W bits (SUM_W = 20 at the default sizes). A word
// goes from accept through PREP, EVICT when the push evicts the oldest pair, DIV,
// WAIT and DONE back to IDLE. A query of an empty window skips the divide, and a
// slot_id out of range goes straight from IDLE to DONE.
// One word is in flight at a time; a finished result sits in the output register
// while the next input word is taken. Writing window_length (0 reads as 1, values
// above MAX_WINDOW as MAX_WINDOW) empties every window at once; the sample RAMs
// hold stale data that is never read before it is rewritten. The config write is
// always ready and must only be issued while the core is idle.
module per_slot_window_average_core import psw_pkg::*; #(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // slots beyond what slot_id can address never exist
    localparam int NS_EFF = (NUM_SLOTS < 2 ** SLOT_ID_W) ? NUM_SLOTS : 2 ** SLOT_ID_W;
    // longest window the register can select
    localparam int WMAX   = (MAX_WINDOW < 2 ** CFG_W - 1) ? MAX_WINDOW : 2 ** CFG_W - 1;
    localparam int WL_RST = (WMAX < 16) ? WMAX : 16;
    localparam int CW     = $clog2(WMAX + 1);
    localparam int PW     = (WMAX > 1) ? $clog2(WMAX) : 1;
    localparam int SLW    = (NS_EFF > 1) ? $clog2(NS_EFF) : 1;
    localparam int SUM_W  = SAMPLE_W + $clog2(WMAX);
    localparam int AW     = SLW + PW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_EVICT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_wl;

    // word being worked on
    logic                r_func;
    logic [SLOT_ID_W-1:0] r_slot;
    logic [SAMPLE_W-1:0] r_q;
    logic [SAMPLE_W-1:0] r_r;

    // per-slot bookkeeping
    logic [SUM_W-1:0]    r_qsum [NS_EFF];
    logic [SUM_W-1:0]    r_rsum [NS_EFF];
    logic [PW-1:0]       r_old  [NS_EFF];
    logic [CW-1:0]       r_fill [NS_EFF];
    logic [SUM_W-1:0]    n_qsum, n_rsum;
    logic [PW-1:0]       n_old;
    logic [CW-1:0]       n_fill;

    t_out_word           r_res;
    t_out_word           r_out;
    logic                r_out_valid;

    logic                w_take, w_cfg_wr, w_in_range;
    logic                w_ins, w_evict, w_zero, w_div_go, w_res_ld, w_out_ld;
    logic [SLW-1:0]      w_idx;
    logic                w_full;
    logic [CW:0]         w_psum, w_pwrap, w_onext;
    logic [PW-1:0]       w_pos, w_old_nx;
    logic [SAMPLE_W-1:0] w_ram_q, w_ram_r;
    logic [CW-1:0]       w_clamp;
    logic                w_qdone, w_rdone;
    logic [SUM_W-1:0]    w_qquot, w_rquot;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_take      = i_in_valid && o_in_ready;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_in_range  = ({1'b0, i_in.slot_id} < (SLOT_ID_W + 1)'(NS_EFF));
    assign w_idx       = r_slot[SLW-1:0];
    assign w_full      = !(r_fill[w_idx] < r_wl);

    // 0 reads as 1, anything past the longest window saturates
    always_comb begin
        if (i_cfg_data == '0) begin
            w_clamp = CW'(1);
        end else if (i_cfg_data > CFG_W'(WMAX)) begin
            w_clamp = CW'(WMAX);
        end else begin
            w_clamp = CW'(i_cfg_data);
        end
    end

    // ring positions: next free entry, and the oldest one after an eviction
    always_comb begin
        w_psum  = (CW + 1)'(r_old[w_idx]) + (CW + 1)'(r_fill[w_idx]);
        w_pwrap = (w_psum >= (CW + 1)'(r_wl)) ? w_psum - (CW + 1)'(r_wl) : w_psum;
        w_pos   = w_pwrap[PW-1:0];
        w_onext = (CW + 1)'(r_old[w_idx]) + (CW + 1)'(1);
        w_old_nx = (w_onext >= (CW + 1)'(r_wl)) ? '0 : w_onext[PW-1:0];
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        w_ins    = 1'b0;
        w_evict  = 1'b0;
        w_zero   = 1'b0;
        w_div_go = 1'b0;
        w_res_ld = 1'b0;
        w_out_ld = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (w_in_range) begin
                        n_state = S_PREP;
                    end else begin
                        w_zero  = 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_PREP: begin
                if (r_func == FUNC_PUSH) begin
                    if (w_full) begin
                        n_state = S_EVICT;      // oldest pair read this cycle
                    end else begin
                        w_ins   = 1'b1;
                        n_state = S_DIV;
                    end
                end else begin
                    n_state = S_DIV;
                end
            end
            S_EVICT: begin
                w_evict = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_fill[w_idx] == '0) begin
                    w_zero  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_div_go = 1'b1;
                    n_state  = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_qdone) begin
                    w_res_ld = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_ld = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slot update: plain insert, or swap the oldest pair for the new one
    always_comb begin
        n_qsum = r_qsum[w_idx];
        n_rsum = r_rsum[w_idx];
        n_old  = r_old[w_idx];
        n_fill = r_fill[w_idx];
        if (w_ins) begin
            n_qsum = r_qsum[w_idx] + SUM_W'(r_q);
            n_rsum = r_rsum[w_idx] + SUM_W'(r_r);
            n_fill = r_fill[w_idx] + 1'b1;
        end else if (w_evict) begin
            n_qsum = r_qsum[w_idx] - SUM_W'(w_ram_q) + SUM_W'(r_q);
            n_rsum = r_rsum[w_idx] - SUM_W'(w_ram_r) + SUM_W'(r_r);
            n_old  = w_old_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wl        <= CW'(WL_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_wl <= w_clamp;
            end
            if (w_out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // bookkeeping is emptied by reset and by a window_length write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_wr) begin
            for (int i = 0; i < NS_EFF; i++) begin
                r_qsum[i] <= '0;
                r_rsum[i] <= '0;
                r_old[i]  <= '0;
                r_fill[i] <= '0;
            end
        end else if (w_ins || w_evict) begin
            r_qsum[w_idx] <= n_qsum;
            r_rsum[w_idx] <= n_rsum;
            r_old[w_idx]  <= n_old;
            r_fill[w_idx] <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_func <= i_in.func;
            r_slot <= i_in.slot_id;
            r_q    <= i_in.queue_sample;
            r_r    <= i_in.rate_sample;
        end
        if (w_zero) begin
            r_res <= '0;
        end else if (w_res_ld) begin
            r_res.mean_queue   <= w_qquot[SAMPLE_W-1:0];
            r_res.mean_rate    <= w_rquot[SAMPLE_W-1:0];
            r_res.samples_held <= COUNT_W'(r_fill[w_idx]);
        end
        if (w_out_ld) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // sample rings, addressed {slot, ring position}
    psw_ram #(
        .WIDTH  (SAMPLE_W),
        .ADDR_W (AW)
    ) u_queue_store (
        .i_clk   (i_clk),
        .i_we    (w_ins || w_evict),
        .i_waddr ({w_idx, (w_ins ? w_pos : r_old[w_idx])}),
        .i_wdata (r_q),
        .i_raddr ({w_idx, r_old[w_idx]}),
        .o_rdata (w_ram_q)
    );

    psw_ram #(
        .WIDTH  (SAMPLE_W),
        .ADDR_W (AW)
    ) u_rate_store (
        .i_clk   (i_clk),
        .i_we    (w_ins || w_evict),
        .i_waddr ({w_idx, (w_ins ? w_pos : r_old[w_idx])}),
        .i_wdata (r_r),
        .i_raddr ({w_idx, r_old[w_idx]}),
        .o_rdata (w_ram_r)
    );

    // the two means, divided in lockstep
    psw_div_serial #(
        .DW (SUM_W),
        .VW (CW)
    ) u_div_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (r_qsum[w_idx]),
        .i_den   (r_fill[w_idx]),
        .o_done  (w_qdone),
        .o_quot  (w_qquot)
    );

    psw_div_serial #(
        .DW (SUM_W),
        .VW (CW)
    ) u_div_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (r_rsum[w_idx]),
        .i_den   (r_fill[w_idx]),
        .o_done  (w_rdone),
        .o_quot  (w_rquot)
    );

    // both dividers finish on the same cycle
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qdone == w_rdone)
        else $error("dividers out of step");

    // a divider only reports while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qdone |-> r_state == S_WAIT)
        else $error("divider done outside wait state");

    // after a push the window is never empty
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_func == FUNC_PUSH) |-> r_fill[w_idx] != '0)
        else $error("push left window empty");

    // the window length register never holds zero
    a_wl_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wl != '0)
        else $error("window length zero");

endmodule

// ===== bench/per_slot_window_average_core_tb.sv =====
// Self-checking testbench for the per-slot sliding-window average core.
module per_slot_window_average_core_tb;
    import psw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;  // far beyond the slowest correct run
    localparam int LONG_HOLD   = 400;     // output stall long enough to back up the input
    localparam int END_SETTLE  = 40;      // more than one word's divide latency

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_word         in_word   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_word        out_word;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    always #5 clk = ~clk;

    per_slot_window_average_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor: a ring of samples per slot with running sums, the same
    // bookkeeping the core keeps, updated in order of acceptance.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] queue_ring  [NUM_SLOTS_DEF][MAX_WINDOW_DEF];
    logic [SAMPLE_W-1:0] rate_ring   [NUM_SLOTS_DEF][MAX_WINDOW_DEF];
    logic [19:0]         queue_total [NUM_SLOTS_DEF];
    logic [19:0]         rate_total  [NUM_SLOTS_DEF];
    int                  oldest      [NUM_SLOTS_DEF];
    int                  held        [NUM_SLOTS_DEF];
    int                  win_len;

    t_out_word pending_averages[$];   // one expected average per accepted word

    int mismatches      = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int length_writes   = 0;
    int cycle_count     = 0;

    // idling knobs, percent of cycles
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;   // bumped by a test to ask for one long output stall

    // Ring contents are left alone: an entry is always written before it is read.
    function automatic void clear_windows();
        for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
            queue_total[s] = '0;
            rate_total[s]  = '0;
            oldest[s]      = 0;
            held[s]        = 0;
        end
    endfunction

    function automatic void set_window_length(logic [CFG_W-1:0] v);
        // zero reads as one, anything above the ring depth as the full depth
        if (v == 0)
            win_len = 1;
        else if (v > MAX_WINDOW_DEF)
            win_len = MAX_WINDOW_DEF;
        else
            win_len = v;
        clear_windows();
    endfunction

    function automatic t_out_word slot_average(t_in_word w);
        t_out_word avg;
        int        s;
        int        pos;
        avg = '0;
        s   = w.slot_id;
        if (w.func == FUNC_PUSH) begin
            if (held[s] < win_len) begin
                pos = (oldest[s] + held[s]) % win_len;
                held[s]++;
            end else begin
                // window full: the oldest pair drops out of the sums
                pos = oldest[s];
                queue_total[s] -= queue_ring[s][pos];
                rate_total[s]  -= rate_ring[s][pos];
                oldest[s] = (pos + 1 >= win_len) ? 0 : pos + 1;
            end
            queue_ring[s][pos] = w.queue_sample;
            rate_ring[s][pos]  = w.rate_sample;
            queue_total[s] += w.queue_sample;
            rate_total[s]  += w.rate_sample;
        end
        // empty window reports all zeros rather than dividing
        if (held[s] != 0) begin
            avg.mean_queue   = SAMPLE_W'(queue_total[s] / held[s]);
            avg.mean_rate    = SAMPLE_W'(rate_total[s] / held[s]);
            avg.samples_held = COUNT_W'(held[s]);
        end
        return avg;
    endfunction

    // ------------------------------------------------------------------
    // Result checking, sampled at the rising edge
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    always @(posedge clk) begin : check_results
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (pending_averages.size() == 0) begin
                note_mismatch("result word with nothing outstanding", 0,
                              out_word.mean_queue);
            end else begin
                want = pending_averages.pop_front();
                if (out_word.mean_queue !== want.mean_queue)
                    note_mismatch("mean_queue", want.mean_queue, out_word.mean_queue);
                if (out_word.mean_rate !== want.mean_rate)
                    note_mismatch("mean_rate", want.mean_rate, out_word.mean_rate);
                if (out_word.samples_held !== want.samples_held)
                    note_mismatch("samples_held", want.samples_held, out_word.samples_held);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output back-pressure: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    int hold_left    = 0;
    int holds_served = 0;

    always @(negedge clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_averages.size());
            $display("per_slot_window_average_core_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offers one word after a random idle gap; valid stays high afterwards so
    // the next word can follow back to back.
    task automatic send_word(input t_in_word w);
        int        gap;
        t_out_word expected;
        gap = 0;
        while (gap < 64 && $urandom_range(99) < sender_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        expected = slot_average(w);
        pending_averages = {pending_averages, expected};
        words_sent++;
    endtask

    // Sender stops offering and waits for every outstanding result.
    task automatic stop_and_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
    endtask

    // Only written with the core idle: every result back, nothing in flight.
    task automatic write_window_length(input logic [CFG_W-1:0] v);
        stop_and_drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        set_window_length(v);
        length_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word make_word(logic f, int s, int q, int r);
        t_in_word w;
        w.func         = f;
        w.slot_id      = SLOT_ID_W'(s);
        w.queue_sample = SAMPLE_W'(q);
        w.rate_sample  = SAMPLE_W'(r);
        return w;
    endfunction

    // Extremes turn up often so the sums see their limits.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Mostly pushes aimed at a few busy slots, so windows fill and wrap.
    function automatic t_in_word random_sample_word(int busy_slots);
        t_in_word w;
        w.func         = ($urandom_range(99) < 25) ? FUNC_QUERY : FUNC_PUSH;
        w.slot_id      = ($urandom_range(99) < 80)
                         ? SLOT_ID_W'($urandom_range(busy_slots - 1))
                         : SLOT_ID_W'($urandom_range(NUM_SLOTS_DEF - 1));
        w.queue_sample = pick_sample();
        w.rate_sample  = pick_sample();
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        // default window of 16 straight out of reset
        send_word(make_word(FUNC_QUERY, 0, 16'hFFFF, 16'hFFFF));  // empty slot, samples ignored
        send_word(make_word(FUNC_PUSH, 0, 16'hFFFF, 16'hFFFF));
        send_word(make_word(FUNC_PUSH, 0, 16'h0000, 16'h0000));    // truncated halves
        send_word(make_word(FUNC_PUSH, 15, 16'h0000, 16'hFFFF));
        send_word(make_word(FUNC_QUERY, 15, 16'h1234, 16'h5678));
        // zero is taken as a window of one: each push replaces the last
        write_window_length(5'd0);
        send_word(make_word(FUNC_PUSH, 2, 16'h1234, 16'hABCD));
        send_word(make_word(FUNC_PUSH, 2, 16'hFFFF, 16'h0000));
        send_word(make_word(FUNC_QUERY, 2, 16'h0000, 16'h0000));
        // window of two: third push wraps the ring
        write_window_length(5'd2);
        send_word(make_word(FUNC_PUSH, 4, 16'h0010, 16'h0100));
        send_word(make_word(FUNC_PUSH, 4, 16'h0031, 16'h0201));
        send_word(make_word(FUNC_PUSH, 4, 16'hFFFF, 16'h0003));
        // above the ring depth clamps to 16: largest possible sums
        write_window_length(5'd31);
        repeat (16) send_word(make_word(FUNC_PUSH, 9, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_idle_phases();
        int               sender_mix[4]   = '{0, 54, 0, 28};
        int               receiver_mix[4] = '{0, 0, 54, 28};
        logic [CFG_W-1:0] lengths[4]      = '{5'd3, 5'd16, 5'd1, 5'd0};
        for (int p = 0; p < 4; p++) begin
            write_window_length((p == 3) ? 5'($urandom_range(31)) : lengths[p]);
            sender_idle_pct    = sender_mix[p];
            receiver_stall_pct = receiver_mix[p];
            repeat (150) send_word(random_sample_word(p + 2));
        end
    endtask

    task automatic test_long_backpressure();
        write_window_length(5'd7);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // output held off while the sender keeps offering: input must stall
        hold_requests++;
        repeat (30) send_word(random_sample_word(2));
        // sender pauses until the core has handed everything back
        stop_and_drain();
        repeat (20) send_word(random_sample_word(3));
    endtask

    initial begin
        set_window_length(5'(MAX_WINDOW_DEF));
        length_writes = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_idle_phases();
        test_long_backpressure();

        stop_and_drain();
        repeat (END_SETTLE) @(posedge clk);

        $display("Sent %0d words and checked %0d results over %0d window-length writes,",
                 words_sent, results_checked, length_writes);
        $display("under four idling mixes with one long output stall; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending_averages.size() == 0)
            $display("per_slot_window_average_core_tb passed");
        else
            $display("per_slot_window_average_core_tb failed");
        $finish;
    end

endmodule

// ===== per_slot_window_average_core.f =====
sv/psw_pkg.sv
sv/psw_ram.sv
sv/psw_div_serial.sv
sv/per_slot_window_average_core.sv
bench/per_slot_window_average_core_tb.sv
